// ----- rtl/itc_pkg.sv -----
// Package for the interval timer counter channel.
// Holds widths, field types, bus codes and control byte values; no dependencies.
`timescale 1ns / 1ps

package itc_pkg;

  // Counter width; 0 written as a reload stands for 2^COUNTER_BITS.
  localparam int COUNTER_BITS = 16;
  // Wide scratch width used for byte merges and byte extraction.
  localparam int WIDE_BITS    = 32;

  typedef logic [COUNTER_BITS-1:0] count_t;
  typedef logic [WIDE_BITS-1:0]    wide_t;
  typedef logic [1:0]              kind_t;
  typedef logic [1:0]              port_t;
  typedef logic [7:0]              byte_t;
  typedef logic [2:0]              mode_t;

  // Item kinds
  localparam kind_t KIND_TICK  = 2'd0;
  localparam kind_t KIND_WRITE = 2'd1;
  localparam kind_t KIND_READ  = 2'd2;

  // Register offsets
  localparam port_t PORT_DATA0 = 2'd0;
  localparam port_t PORT_CTRL  = 2'd3;

  // Control bytes
  localparam byte_t CTL_LATCH = 8'h00;
  localparam byte_t CTL_MODE0 = 8'h30;
  localparam byte_t CTL_MODE2 = 8'h34;
  localparam byte_t CTL_MODE4 = 8'h38;

  // Operating modes
  localparam mode_t MODE_INT_TC = 3'd0;
  localparam mode_t MODE_RATE   = 3'd2;
  localparam mode_t MODE_STROBE = 3'd4;

  localparam count_t COUNT_ZERO = count_t'(0);
  localparam count_t COUNT_ONE  = count_t'(1);

endpackage

// ----- rtl/itc_if.sv -----
// Valid/ready channel interfaces for request items and result items.
// Depends on itc_pkg for the field types.
`timescale 1ns / 1ps

interface itc_req_if;
  logic           valid;
  logic           ready;
  itc_pkg::kind_t kind;
  itc_pkg::port_t port;
  itc_pkg::byte_t wdata;

  modport source (output valid, output kind, output port, output wdata, input ready);
  modport sink   (input valid, input kind, input port, input wdata, output ready);
endinterface

interface itc_rsp_if;
  logic           valid;
  logic           ready;
  itc_pkg::byte_t rdata;
  logic           out_level;
  logic           event_pulse;
  logic           ignored;

  modport source (output valid, output rdata, output out_level, output event_pulse,
                  output ignored, input ready);
  modport sink   (input valid, input rdata, input out_level, input event_pulse,
                  input ignored, output ready);
endinterface

// ----- rtl/interval_timer_counter_channel_top.sv -----
// Top level of the interval timer counter channel (channel 0, modes 0/2/4).
// Depends on itc_pkg and the channel interfaces in itc_if.sv.
//
//   channel | dir | payload                                  | transfer when
//   req     | in  | kind[1:0] port[1:0] wdata[7:0]           | valid && ready
//   rsp     | out | rdata[7:0] out_level event_pulse ignored | valid && ready
//
// Each item passes an input register, then the update logic into the result
// register: one item per cycle sustained while rsp does not stall. The
// limit is the single state update per cycle (count decrement and compare).
// Synchronous active-high reset clears control state and the timer state to
// its power-on values (output pin high, counting stopped).
// A stall on rsp holds the result register; the input register still takes
// one item, then req drops ready until the result moves on.
`timescale 1ns / 1ps

module interval_timer_counter_channel_top (
  input  logic         clk,
  input  logic         rst,
  itc_req_if.sink      req,
  itc_rsp_if.source    rsp
);

  // Input register stage
  logic            stage_valid;
  itc_pkg::kind_t  stage_kind;
  itc_pkg::port_t  stage_port;
  itc_pkg::byte_t  stage_wdata;

  // Timer state
  itc_pkg::mode_t  mode;
  itc_pkg::count_t reload_value;
  itc_pkg::count_t current_count;
  itc_pkg::count_t latched_value;
  logic            latch_held;
  logic            write_expect_msb;
  logic            read_expect_msb;
  logic            counting;
  logic            output_pin;
  logic            armed;

  // Next-state values
  itc_pkg::mode_t  mode_next;
  itc_pkg::count_t reload_value_next;
  itc_pkg::count_t current_count_next;
  itc_pkg::count_t latched_value_next;
  logic            latch_held_next;
  logic            write_expect_msb_next;
  logic            read_expect_msb_next;
  logic            counting_next;
  logic            output_pin_next;
  logic            armed_next;
  itc_pkg::byte_t  rdata_next;
  logic            event_next;
  logic            ignored_next;

  // Scratch for byte merge and read selection
  itc_pkg::wide_t  reload_wide;
  itc_pkg::wide_t  read_wide;
  itc_pkg::count_t count_dec;

  logic advance;

  // Advance the stage when the result register is free or is being taken.
  assign advance   = stage_valid && (!rsp.valid || rsp.ready);
  assign req.ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req.ready) begin
      stage_valid <= req.valid;
    end
    if (req.valid && req.ready) begin
      stage_kind  <= req.kind;
      stage_port  <= req.port;
      stage_wdata <= req.wdata;
    end
  end

  always_comb begin
    mode_next             = mode;
    reload_value_next     = reload_value;
    current_count_next    = current_count;
    latched_value_next    = latched_value;
    latch_held_next       = latch_held;
    write_expect_msb_next = write_expect_msb;
    read_expect_msb_next  = read_expect_msb;
    counting_next         = counting;
    output_pin_next       = output_pin;
    armed_next            = armed;
    rdata_next            = '0;
    event_next            = 1'b0;
    ignored_next          = 1'b0;
    reload_wide           = itc_pkg::wide_t'(reload_value);
    read_wide             = itc_pkg::wide_t'(latch_held ? latched_value : current_count);
    count_dec             = current_count - itc_pkg::COUNT_ONE;

    case (stage_kind)
      itc_pkg::KIND_TICK: begin
        if (counting) begin
          if (mode == itc_pkg::MODE_RATE) begin
            // Rate generator: reload on a count of one, low for one tick before.
            if (current_count == itc_pkg::COUNT_ONE) begin
              current_count_next = reload_value;
              output_pin_next    = 1'b1;
            end else begin
              current_count_next = count_dec;
              if (count_dec == itc_pkg::COUNT_ONE) begin
                output_pin_next = 1'b0;
                event_next      = 1'b1;
              end
            end
          end else begin
            current_count_next = count_dec;
            if (mode == itc_pkg::MODE_STROBE && !output_pin) begin
              output_pin_next = 1'b1;
            end
            // Terminal count fires once per load.
            if (count_dec == itc_pkg::COUNT_ZERO && armed) begin
              armed_next      = 1'b0;
              event_next      = 1'b1;
              output_pin_next = (mode == itc_pkg::MODE_INT_TC);
            end
          end
        end
      end

      itc_pkg::KIND_WRITE: begin
        if (stage_port == itc_pkg::PORT_CTRL) begin
          if (stage_wdata[7:6] != 2'b00) begin
            // Other counter or read-back: drop.
            ignored_next = 1'b1;
          end else if (stage_wdata[5:4] == itc_pkg::CTL_LATCH[5:4]) begin
            if (!latch_held) begin
              latched_value_next = current_count;
              latch_held_next    = 1'b1;
            end
          end else if (stage_wdata == itc_pkg::CTL_MODE0 ||
                       stage_wdata == itc_pkg::CTL_MODE2 ||
                       stage_wdata == itc_pkg::CTL_MODE4) begin
            if (stage_wdata == itc_pkg::CTL_MODE0) begin
              mode_next = itc_pkg::MODE_INT_TC;
            end else if (stage_wdata == itc_pkg::CTL_MODE2) begin
              mode_next = itc_pkg::MODE_RATE;
            end else begin
              mode_next = itc_pkg::MODE_STROBE;
            end
            counting_next         = 1'b0;
            latch_held_next       = 1'b0;
            write_expect_msb_next = 1'b0;
            read_expect_msb_next  = 1'b0;
            armed_next            = 1'b0;
            output_pin_next       = (stage_wdata != itc_pkg::CTL_MODE0);
          end else begin
            // Other mode, other access or BCD: drop.
            ignored_next = 1'b1;
          end
        end else if (stage_port == itc_pkg::PORT_DATA0) begin
          if (!write_expect_msb) begin
            reload_wide[7:0]      = stage_wdata;
            reload_value_next     = reload_wide[itc_pkg::COUNTER_BITS-1:0];
            write_expect_msb_next = 1'b1;
            if (mode == itc_pkg::MODE_INT_TC) begin
              counting_next   = 1'b0;
              output_pin_next = 1'b0;
            end
          end else begin
            reload_wide[15:8]     = stage_wdata;
            reload_value_next     = reload_wide[itc_pkg::COUNTER_BITS-1:0];
            write_expect_msb_next = 1'b0;
            // A running rate generator picks up the new value at its next reload.
            if (!(mode == itc_pkg::MODE_RATE && counting)) begin
              current_count_next = reload_wide[itc_pkg::COUNTER_BITS-1:0];
              counting_next      = 1'b1;
              armed_next         = 1'b1;
              output_pin_next    = (mode != itc_pkg::MODE_INT_TC);
            end
          end
        end else begin
          ignored_next = 1'b1;
        end
      end

      itc_pkg::KIND_READ: begin
        if (stage_port == itc_pkg::PORT_DATA0) begin
          if (!read_expect_msb) begin
            rdata_next           = read_wide[7:0];
            read_expect_msb_next = 1'b1;
          end else begin
            rdata_next           = read_wide[15:8];
            read_expect_msb_next = 1'b0;
            latch_held_next      = 1'b0;
          end
        end else begin
          ignored_next = 1'b1;
        end
      end

      default: begin
        ignored_next = 1'b1;
      end
    endcase
  end

  // Commit state and load the result register on advance.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= itc_pkg::MODE_INT_TC;
      reload_value     <= '0;
      current_count    <= '0;
      latched_value    <= '0;
      latch_held       <= 1'b0;
      write_expect_msb <= 1'b0;
      read_expect_msb  <= 1'b0;
      counting         <= 1'b0;
      output_pin       <= 1'b1;
      armed            <= 1'b0;
      rsp.valid        <= 1'b0;
    end else begin
      if (advance) begin
        mode             <= mode_next;
        reload_value     <= reload_value_next;
        current_count    <= current_count_next;
        latched_value    <= latched_value_next;
        latch_held       <= latch_held_next;
        write_expect_msb <= write_expect_msb_next;
        read_expect_msb  <= read_expect_msb_next;
        counting         <= counting_next;
        output_pin       <= output_pin_next;
        armed            <= armed_next;
        rsp.valid        <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
    if (advance) begin
      rsp.rdata       <= rdata_next;
      rsp.out_level   <= output_pin_next;
      rsp.event_pulse <= event_next;
      rsp.ignored     <= ignored_next;
    end
  end

endmodule

// ----- test/tb_interval_timer_counter_channel_top.sv -----
// Testbench for the interval timer counter channel (channel 0, modes 0/2/4).
// Depends on itc_pkg, the channel interfaces in itc_if.sv and the top level RTL.
// An item-level timer predictor is checked against every result transfer.
`timescale 1ns / 1ps

module tb_interval_timer_counter_channel_top;

  // Codes the package does not name
  localparam itc_pkg::kind_t KIND_NONE    = 2'd3;
  localparam itc_pkg::port_t PORT_CH1     = 2'd1;
  localparam itc_pkg::port_t PORT_CH2     = 2'd2;
  localparam itc_pkg::byte_t SELECT_MASK  = 8'hC0;  // counter select bits of a control byte
  localparam itc_pkg::byte_t ACCESS_MASK  = 8'h30;  // access bits of a control byte
  localparam itc_pkg::byte_t CTL_CH1      = 8'h40;
  localparam itc_pkg::byte_t CTL_READBACK = 8'hC0;
  localparam itc_pkg::byte_t CTL_MODE0_BCD = 8'h31;

  typedef struct packed {
    itc_pkg::byte_t rdata;
    logic           out_level;
    logic           event_pulse;
    logic           ignored;
  } timer_result_t;

  logic clk = 1'b0;
  logic rst;

  itc_req_if req_if ();
  itc_rsp_if rsp_if ();

  interval_timer_counter_channel_top u_top (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Timer state as seen by the predictor, starting at power-on values
  itc_pkg::mode_t  tm_mode       = itc_pkg::MODE_INT_TC;
  itc_pkg::count_t tm_reload     = itc_pkg::COUNT_ZERO;
  itc_pkg::count_t tm_count      = itc_pkg::COUNT_ZERO;
  itc_pkg::count_t tm_latched    = itc_pkg::COUNT_ZERO;
  logic            tm_latch_held = 1'b0;
  logic            tm_wr_msb     = 1'b0;
  logic            tm_rd_msb     = 1'b0;
  logic            tm_running    = 1'b0;
  logic            tm_pin        = 1'b1;
  logic            tm_armed      = 1'b0;

  timer_result_t expected_q[$];

  int src_idle_pct   = 0;
  int rcv_stall_pct  = 0;
  int hold_off_left  = 0;
  int errors         = 0;
  int transfers_in   = 0;
  int useful_in      = 0;
  int results_seen   = 0;
  int events_seen    = 0;
  int rejects_seen   = 0;

  // Advance the timer by one item and return the result it produces.
  function automatic timer_result_t timer_step(itc_pkg::kind_t k, itc_pkg::port_t p,
                                               itc_pkg::byte_t w);
    timer_result_t   r;
    itc_pkg::wide_t  scratch;
    itc_pkg::count_t shown;
    r = '0;
    case (k)
      itc_pkg::KIND_TICK: begin
        if (tm_running) begin
          if (tm_mode == itc_pkg::MODE_RATE) begin
            if (tm_count == itc_pkg::COUNT_ONE) begin
              tm_count = tm_reload;
              tm_pin   = 1'b1;
            end else begin
              tm_count = tm_count - itc_pkg::COUNT_ONE;
              if (tm_count == itc_pkg::COUNT_ONE) begin
                tm_pin        = 1'b0;
                r.event_pulse = 1'b1;
              end
            end
          end else begin
            tm_count = tm_count - itc_pkg::COUNT_ONE;
            if (tm_mode == itc_pkg::MODE_STROBE && !tm_pin) tm_pin = 1'b1;
            if (tm_count == itc_pkg::COUNT_ZERO && tm_armed) begin
              tm_armed      = 1'b0;
              r.event_pulse = 1'b1;
              tm_pin        = (tm_mode == itc_pkg::MODE_INT_TC);
            end
          end
        end
      end
      itc_pkg::KIND_WRITE: begin
        if (p == itc_pkg::PORT_CTRL) begin
          if ((w & SELECT_MASK) != 8'h00) begin
            r.ignored = 1'b1;
          end else if ((w & ACCESS_MASK) == itc_pkg::CTL_LATCH) begin
            // a second latch while one is held is dropped
            if (!tm_latch_held) begin
              tm_latched    = tm_count;
              tm_latch_held = 1'b1;
            end
          end else if (w == itc_pkg::CTL_MODE0 || w == itc_pkg::CTL_MODE2 ||
                       w == itc_pkg::CTL_MODE4) begin
            tm_mode = (w == itc_pkg::CTL_MODE0) ? itc_pkg::MODE_INT_TC :
                      (w == itc_pkg::CTL_MODE2) ? itc_pkg::MODE_RATE : itc_pkg::MODE_STROBE;
            tm_running    = 1'b0;
            tm_latch_held = 1'b0;
            tm_wr_msb     = 1'b0;
            tm_rd_msb     = 1'b0;
            tm_armed      = 1'b0;
            tm_pin        = (tm_mode != itc_pkg::MODE_INT_TC);
          end else begin
            r.ignored = 1'b1;
          end
        end else if (p == itc_pkg::PORT_DATA0) begin
          scratch = itc_pkg::wide_t'(tm_reload);
          if (!tm_wr_msb) begin
            scratch[7:0] = w;
            tm_reload    = itc_pkg::count_t'(scratch);
            tm_wr_msb    = 1'b1;
            if (tm_mode == itc_pkg::MODE_INT_TC) begin
              tm_running = 1'b0;
              tm_pin     = 1'b0;
            end
          end else begin
            scratch[15:8] = w;
            tm_reload     = itc_pkg::count_t'(scratch);
            tm_wr_msb     = 1'b0;
            // a rate generator that is running picks the value up at its next reload
            if (!(tm_mode == itc_pkg::MODE_RATE && tm_running)) begin
              tm_count   = tm_reload;
              tm_running = 1'b1;
              tm_armed   = 1'b1;
              tm_pin     = (tm_mode != itc_pkg::MODE_INT_TC);
            end
          end
        end else begin
          r.ignored = 1'b1;
        end
      end
      itc_pkg::KIND_READ: begin
        if (p == itc_pkg::PORT_DATA0) begin
          shown   = tm_latch_held ? tm_latched : tm_count;
          scratch = itc_pkg::wide_t'(shown);
          if (!tm_rd_msb) begin
            r.rdata   = scratch[7:0];
            tm_rd_msb = 1'b1;
          end else begin
            r.rdata       = scratch[15:8];
            tm_rd_msb     = 1'b0;
            tm_latch_held = 1'b0;
          end
        end else begin
          r.ignored = 1'b1;
        end
      end
      default: r.ignored = 1'b1;
    endcase
    r.out_level = tm_pin;
    return r;
  endfunction

  // Offer one item, wait for its transfer, then queue its predicted result.
  task automatic send_item(input itc_pkg::kind_t k, input itc_pkg::port_t p,
                           input itc_pkg::byte_t w);
    timer_result_t exp_r;
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.kind  <= k;
    req_if.port  <= p;
    req_if.wdata <= w;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    exp_r = timer_step(k, p, w);
    expected_q.push_back(exp_r);
    transfers_in++;
    if (!exp_r.ignored) useful_in++;
  endtask

  task automatic load_count(input itc_pkg::count_t value);
    itc_pkg::wide_t v;
    v = itc_pkg::wide_t'(value);
    send_item(itc_pkg::KIND_WRITE, itc_pkg::PORT_DATA0, v[7:0]);
    send_item(itc_pkg::KIND_WRITE, itc_pkg::PORT_DATA0, v[15:8]);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(itc_pkg::KIND_TICK, itc_pkg::PORT_DATA0, itc_pkg::byte_t'($urandom));
  endtask

  // Mostly short counts so terminal counts come often; now and then a wide one.
  function automatic itc_pkg::count_t pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 70) return itc_pkg::count_t'($urandom_range(1, 12));
    if (r < 88) return itc_pkg::count_t'($urandom_range(0, 400));
    return itc_pkg::count_t'($urandom);
  endfunction

  // Result side: check each transfer against the oldest prediction, then pick
  // the next ready level (long hold-off first, else random stalls).
  always @(posedge clk) begin
    timer_result_t exp_r;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      results_seen++;
      if (rsp_if.event_pulse === 1'b1) events_seen++;
      if (rsp_if.ignored === 1'b1) rejects_seen++;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected, got rdata %0h level %0b event %0b ign %0b",
                 $time, rsp_if.rdata, rsp_if.out_level, rsp_if.event_pulse, rsp_if.ignored);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (rsp_if.rdata !== exp_r.rdata) begin
          $display("%0t: rdata mismatch, expected %0h, got %0h",
                   $time, exp_r.rdata, rsp_if.rdata);
          errors++;
        end
        if (rsp_if.out_level !== exp_r.out_level) begin
          $display("%0t: out_level mismatch, expected %0b, got %0b",
                   $time, exp_r.out_level, rsp_if.out_level);
          errors++;
        end
        if (rsp_if.event_pulse !== exp_r.event_pulse) begin
          $display("%0t: event_pulse mismatch, expected %0b, got %0b",
                   $time, exp_r.event_pulse, rsp_if.event_pulse);
          errors++;
        end
        if (rsp_if.ignored !== exp_r.ignored) begin
          $display("%0t: ignored mismatch, expected %0b, got %0b",
                   $time, exp_r.ignored, rsp_if.ignored);
          errors++;
        end
      end
    end
    if (hold_off_left > 0) begin
      hold_off_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // A read straight after reset and a tick that must not count.
  task automatic test_power_on();
    send_item(itc_pkg::KIND_READ, itc_pkg::PORT_DATA0, 8'h00);
    send_item(itc_pkg::KIND_TICK, itc_pkg::PORT_DATA0, 8'h00);
  endtask

  // Mode 0: terminal count raises the pin once; latch, repeated latch, readout.
  task automatic test_interrupt_on_terminal();
    send_item(itc_pkg::KIND_WRITE, itc_pkg::PORT_CTRL, itc_pkg::CTL_MODE0);
    load_count(itc_pkg::count_t'(2));
    send_ticks(2);
    send_item(itc_pkg::KIND_WRITE, itc_pkg::PORT_CTRL, itc_pkg::CTL_LATCH);
    send_ticks(1);
    send_item(itc_pkg::KIND_WRITE, itc_pkg::PORT_CTRL, itc_pkg::CTL_LATCH);
    send_item(itc_pkg::KIND_READ, itc_pkg::PORT_DATA0, 8'h00);
    send_item(itc_pkg::KIND_READ, itc_pkg::PORT_DATA0, 8'h00);
  endtask

  // Mode 2: low for one tick at count 1, then reload and back high.
  task automatic test_rate_generator();
    send_item(itc_pkg::KIND_WRITE, itc_pkg::PORT_CTRL, itc_pkg::CTL_MODE2);
    load_count(itc_pkg::count_t'(2));
    send_ticks(2);
  endtask

  // Mode 4: full-scale byte values, then a strobe from a count of 1.
  task automatic test_strobe();
    send_item(itc_pkg::KIND_WRITE, itc_pkg::PORT_CTRL, itc_pkg::CTL_MODE4);
    load_count(itc_pkg::count_t'(16'hFFFF));
    load_count(itc_pkg::count_t'(1));
    send_ticks(2);
  endtask

  // Accesses the channel does not support change nothing and are flagged.
  task automatic test_rejected_access();
    send_item(itc_pkg::KIND_WRITE, PORT_CH1, 8'hFF);
    send_item(itc_pkg::KIND_READ, itc_pkg::PORT_CTRL, 8'h00);
    send_item(KIND_NONE, PORT_CH2, 8'hA5);
    send_item(itc_pkg::KIND_WRITE, itc_pkg::PORT_CTRL, CTL_CH1);
    send_item(itc_pkg::KIND_WRITE, itc_pkg::PORT_CTRL, CTL_READBACK);
    send_item(itc_pkg::KIND_WRITE, itc_pkg::PORT_CTRL, CTL_MODE0_BCD);
  endtask

  // Hold the result side off for a long stretch while items keep coming,
  // so the pipeline fills and the request side has to drop ready.
  task automatic test_stall_fill();
    src_idle_pct  = 0;
    rcv_stall_pct = 0;
    hold_off_left = 60;
    send_item(itc_pkg::KIND_WRITE, itc_pkg::PORT_CTRL, itc_pkg::CTL_MODE2);
    load_count(itc_pkg::count_t'(3));
    send_ticks(12);
    send_item(itc_pkg::KIND_READ, itc_pkg::PORT_DATA0, 8'h00);
    send_item(itc_pkg::KIND_READ, itc_pkg::PORT_DATA0, 8'h00);
  endtask

  // Mostly program/load/run sequences with random content, plus raw noise.
  task automatic test_random_traffic(input int n, input int src_pct, input int rcv_pct);
    int             stop_at;
    int             sel;
    itc_pkg::byte_t ctl;
    src_idle_pct  = src_pct;
    rcv_stall_pct = rcv_pct;
    stop_at = useful_in + n;
    while (useful_in < stop_at) begin
      if ($urandom_range(99) < 70) begin
        case ($urandom_range(2))
          0:       ctl = itc_pkg::CTL_MODE0;
          1:       ctl = itc_pkg::CTL_MODE2;
          default: ctl = itc_pkg::CTL_MODE4;
        endcase
        send_item(itc_pkg::KIND_WRITE, itc_pkg::PORT_CTRL, ctl);
        load_count(pick_count());
        repeat ($urandom_range(3, 24)) begin
          sel = $urandom_range(99);
          if (sel < 68)
            send_item(itc_pkg::KIND_TICK, itc_pkg::port_t'($urandom_range(3)),
                      itc_pkg::byte_t'($urandom));
          else if (sel < 80)
            send_item(itc_pkg::KIND_READ, itc_pkg::PORT_DATA0, itc_pkg::byte_t'($urandom));
          else if (sel < 88)
            send_item(itc_pkg::KIND_WRITE, itc_pkg::PORT_CTRL,
                      itc_pkg::CTL_LATCH | itc_pkg::byte_t'($urandom_range(15)));
          else
            send_item(itc_pkg::KIND_WRITE, itc_pkg::PORT_DATA0,
                      itc_pkg::byte_t'($urandom_range(0, 3) == 0 ?
                                       $urandom : $urandom_range(0, 6)));
        end
      end else begin
        send_item(itc_pkg::kind_t'($urandom_range(3)), itc_pkg::port_t'($urandom_range(3)),
                  itc_pkg::byte_t'($urandom));
      end
    end
  endtask

  initial begin
    int waited;
    rst          = 1'b1;
    req_if.valid = 1'b0;
    req_if.kind  = itc_pkg::KIND_TICK;
    req_if.port  = itc_pkg::PORT_DATA0;
    req_if.wdata = 8'h00;
    rsp_if.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_power_on();
    test_interrupt_on_terminal();
    test_rate_generator();
    test_strobe();
    test_rejected_access();
    test_stall_fill();
    test_random_traffic(470, 0, 0);
    test_random_traffic(470, 57, 0);
    test_random_traffic(470, 0, 57);
    test_random_traffic(470, 17, 17);

    // Drop valid, drain the pipeline, then let the clock idle before the final check.
    req_if.valid  <= 1'b0;
    src_idle_pct  = 0;
    rcv_stall_pct = 0;
    waited = 0;
    while (expected_q.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (expected_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_q.size());
      errors++;
    end

    $display("Run covered %0d request transfers (%0d acted on) and %0d result transfers,",
             transfers_in, useful_in, results_seen);
    $display("with %0d terminal-count events and %0d rejected accesses; %0d mismatches.",
             events_seen, rejects_seen, errors);
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/itc_pkg.sv
rtl/itc_if.sv
rtl/interval_timer_counter_channel_top.sv
test/tb_interval_timer_counter_channel_top.sv
